/* src/mqf_pkg.sv */
// ---------------------------------------------------------------------------
// mqf_pkg: shared types for the multi-queue drop-oldest FIFO bank
// Holds the operation codes, status codes and the request and response
// records that pass between the front end, the command queue and the back end.
// ---------------------------------------------------------------------------
package mqf_pkg;

   // Fixed widths of the request and response fields
   localparam int OP_W    = 2;
   localparam int NODE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int FILL_W  = 7;

   // Operation codes on req_operation (any other code acts as a query)
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

   // Request class decided by the front end
   typedef enum logic [1:0] {
      KIND_BAD   = 2'd0,
      KIND_ENQ   = 2'd1,
      KIND_DEQ   = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_NODE = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   // Classified request as queued between front and back
   typedef struct packed {
      kind_type            kind;
      logic [NODE_W-1:0]   node_id;
      logic [WORD_W-1:0]   payload;
   } cmd_type;

   // One response
   typedef struct packed {
      status_type          status;
      logic [WORD_W-1:0]   read_data;
      logic [FILL_W-1:0]   fill_count;
      logic                is_empty;
      logic                dropped_oldest;
   } rsp_type;

endpackage

/* src/mqf_front.sv */
// ---------------------------------------------------------------------------
// mqf_front: request intake and classification
// Registers one incoming request, checks the node number against the bank
// size and tags it as enqueue, dequeue, query or bad node.
// ---------------------------------------------------------------------------
module mqf_front #(
   parameter int NUM_QUEUES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_operation,
   input  logic [7:0]              req_node_id,
   input  logic [31:0]             req_payload,
   output logic                    push_valid,
   output mqf_pkg::cmd_type        push_cmd,
   input  logic                    push_ready
);
   import mqf_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   cmd_type cls;
   logic    accept;

   // Classify the request on the ports
   always_comb begin
      cls.node_id = req_node_id;
      cls.payload = req_payload;
      if ({1'b0, req_node_id} >= (NODE_W + 1)'(NUM_QUEUES)) begin
         cls.kind = KIND_BAD;
      end else begin
         case (req_operation)
            OP_ENQUEUE: cls.kind = KIND_ENQ;
            OP_DEQUEUE: cls.kind = KIND_DEQ;
            OP_QUERY:   cls.kind = KIND_QUERY;
            default:    cls.kind = KIND_QUERY;
         endcase
      end
   end

   // Hold one request until the command queue takes it
   assign req_stall  = hold_valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_cmd_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = cls;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

/* src/mqf_cmd_fifo.sv */
// ---------------------------------------------------------------------------
// mqf_cmd_fifo: short command queue between front and back
// Two-entry queue of classified requests so that each side stalls on its own.
// ---------------------------------------------------------------------------
module mqf_cmd_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  mqf_pkg::cmd_type        push_cmd,
   output logic                    push_ready,
   output logic                    pop_valid,
   output mqf_pkg::cmd_type        pop_cmd,
   input  logic                    pop
);
   import mqf_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/mqf_back.sv */
// ---------------------------------------------------------------------------
// mqf_back: queue bank execution
// Sequences one command at a time against the per-queue pointer memory and
// the shared entry memory, and loads the response register.
// ---------------------------------------------------------------------------
module mqf_back #(
   parameter int NUM_QUEUES  = 16,
   parameter int QUEUE_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  mqf_pkg::cmd_type        cmd,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mqf_pkg::rsp_type        rsp
);
   import mqf_pkg::*;

   localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW      = $clog2(QUEUE_DEPTH);
   localparam int CW      = $clog2(QUEUE_DEPTH + 1);
   localparam int SW      = ((PW > CW) ? PW : CW) + 1;
   localparam int AW      = QW + PW;
   localparam int ENTRIES = NUM_QUEUES << PW;

   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_PTR  = PW'(QUEUE_DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_SUM = SW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_META = 3'b010,
      ST_DATA = 3'b100
   } state_type;

   typedef struct packed {
      logic [PW-1:0] head;
      logic [CW-1:0] count;
   } meta_type;

   state_type               state_ff, state_in;
   cmd_type                 cur_ff, cur_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [NUM_QUEUES-1:0]   meta_valid_ff, meta_valid_in;

   meta_type                meta_mem [NUM_QUEUES];
   meta_type                meta_rd_ff;
   logic [DATA_WIDTH-1:0]   ent_mem [ENTRIES];
   logic [DATA_WIDTH-1:0]   ent_rd_ff;

   logic                    out_free;
   logic [QW-1:0]           q_new, q_cur;
   logic [PW-1:0]           head, head_next, tail, ent_pos;
   logic [CW-1:0]           count;
   logic [SW-1:0]           sum;
   logic                    full;
   logic                    meta_re, meta_we, ent_re, ent_we;
   meta_type                meta_wdata;
   logic [AW-1:0]           ent_addr;
   logic [DATA_WIDTH-1:0]   ent_wdata;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign q_new     = cmd.node_id[QW-1:0];
   assign q_cur     = cur_ff.node_id[QW-1:0];

   // Pointer arithmetic on the selected queue; a never-written queue reads empty
   assign head      = meta_valid_ff[q_cur] ? meta_rd_ff.head  : '0;
   assign count     = meta_valid_ff[q_cur] ? meta_rd_ff.count : '0;
   assign full      = (count == DEPTH_CNT);
   assign head_next = (head == LAST_PTR) ? '0 : head + PW'(1);
   assign sum       = SW'(head) + SW'(count);
   assign tail      = (sum >= DEPTH_SUM) ? PW'(sum - DEPTH_SUM) : PW'(sum);
   assign ent_pos   = (cur_ff.kind == KIND_ENQ && !full) ? tail : head;
   assign ent_addr  = {q_cur, ent_pos};
   assign ent_wdata = DATA_WIDTH'(cur_ff.payload);

   // Sequence one command
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      meta_valid_in = meta_valid_ff;
      cmd_pop       = 1'b0;
      meta_re       = 1'b0;
      meta_we       = 1'b0;
      meta_wdata    = '0;
      ent_re        = 1'b0;
      ent_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               if (cmd.kind == KIND_BAD) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.status         = STATUS_BAD_NODE;
                  rsp_in.read_data      = '0;
                  rsp_in.fill_count     = '0;
                  rsp_in.is_empty       = 1'b0;
                  rsp_in.dropped_oldest = 1'b0;
               end else begin
                  meta_re  = 1'b1;
                  state_in = ST_META;
               end
            end
         end

         ST_META: begin
            state_in              = ST_IDLE;
            rsp_in.status         = STATUS_OK;
            rsp_in.read_data      = '0;
            rsp_in.dropped_oldest = 1'b0;
            case (cur_ff.kind)
               KIND_ENQ: begin
                  ent_we        = 1'b1;
                  meta_we       = 1'b1;
                  meta_valid_in[q_cur] = 1'b1;
                  if (full) begin
                     // drop the oldest entry and reuse its slot
                     meta_wdata.head       = head_next;
                     meta_wdata.count      = count;
                     rsp_in.dropped_oldest = 1'b1;
                  end else begin
                     meta_wdata.head  = head;
                     meta_wdata.count = count + CW'(1);
                  end
                  rsp_valid_in      = 1'b1;
                  rsp_in.fill_count = FILL_W'(meta_wdata.count);
                  rsp_in.is_empty   = 1'b0;
               end
               KIND_DEQ: begin
                  if (count == '0) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.status     = STATUS_EMPTY;
                     rsp_in.fill_count = '0;
                     rsp_in.is_empty   = 1'b1;
                  end else begin
                     ent_re               = 1'b1;
                     meta_we              = 1'b1;
                     meta_valid_in[q_cur] = 1'b1;
                     meta_wdata.head      = head_next;
                     meta_wdata.count     = count - CW'(1);
                     cnt_in               = count - CW'(1);
                     state_in             = ST_DATA;
                  end
               end
               default: begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.fill_count = FILL_W'(count);
                  rsp_in.is_empty   = (count == '0);
               end
            endcase
         end

         ST_DATA: begin
            state_in              = ST_IDLE;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = STATUS_OK;
            rsp_in.read_data      = WORD_W'(ent_rd_ff);
            rsp_in.fill_count     = FILL_W'(cnt_ff);
            rsp_in.is_empty       = (cnt_ff == '0);
            rsp_in.dropped_oldest = 1'b0;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         meta_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         meta_valid_ff <= meta_valid_in;
      end
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   // Per-queue head and count memory
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[q_cur] <= meta_wdata;
      end
      if (meta_re) begin
         meta_rd_ff <= meta_mem[q_new];
      end
   end

   // Shared entry memory, one region per queue
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_addr] <= ent_wdata;
      end
      if (ent_re) begin
         ent_rd_ff <= ent_mem[ent_addr];
      end
   end

endmodule

/* src/multi_queue_fifo_drop_oldest_unit.sv */
// ---------------------------------------------------------------------------
// multi_queue_fifo_drop_oldest_unit: bank of per-node drop-oldest FIFOs
// Top level joining the request front end, the command queue and the back end.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_* (valid/stall): an operation (enqueue, dequeue,
//   query), a node number and a payload word. Each request gives exactly one
//   response on rsp_* (valid/stall) with status, dequeued word, fill count,
//   empty flag and a drop flag, in request order.
//   An enqueue onto a full queue drops that queue's oldest word first.
//   The back end handles one request at a time; a bad node is answered
//   straight from the command, while enqueue, query and empty dequeue first
//   wait for the registered read of the pointer memory, and a dequeue with
//   data then also for the registered read of the entry memory.
//   Reset empties every queue at once; no clearing pass is needed.
//   While rsp_stall is high the response holds; an input register and a
//   two-entry command queue keep taking requests until they fill.
// ---------------------------------------------------------------------------
module multi_queue_fifo_drop_oldest_unit #(
   parameter int NUM_QUEUES  = 16,
   parameter int QUEUE_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_operation,
   input  logic [7:0]   req_node_id,
   input  logic [31:0]  req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [31:0]  rsp_read_data,
   output logic [6:0]   rsp_fill_count,
   output logic         rsp_is_empty,
   output logic         rsp_dropped_oldest
);
   import mqf_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop;
   cmd_type pop_cmd;
   rsp_type rsp;

   // Intake and classify
   mqf_front #(
      .NUM_QUEUES (NUM_QUEUES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_node_id   (req_node_id),
      .req_payload   (req_payload),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd),
      .push_ready    (push_ready)
   );

   // Decouple front and back
   mqf_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   // Execute against the queue memories
   mqf_back #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Unpack the response
   assign rsp_status         = rsp.status;
   assign rsp_read_data      = rsp.read_data;
   assign rsp_fill_count     = rsp.fill_count;
   assign rsp_is_empty       = rsp.is_empty;
   assign rsp_dropped_oldest = rsp.dropped_oldest;

endmodule
